// ===== design/rau_pkg.sv =====
// ----------------------------------------------------------------------------
// rau_pkg
// Shared types and constants of the rational arithmetic unit.
// ----------------------------------------------------------------------------
`default_nettype none

package rau_pkg;

  localparam int unsigned ValueWidthDefault = 32;

  typedef enum logic [2:0] {
    MODE_ADD = 3'd0,
    MODE_SUB = 3'd1,
    MODE_MUL = 3'd2,
    MODE_DIV = 3'd3,
    MODE_EQ  = 3'd4,
    MODE_LT  = 3'd5
  } mode_e;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_ZERO_DEN = 2'd1,
    ST_DIV_ZERO = 2'd2,
    ST_OVERFLOW = 2'd3
  } status_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_CHECK,
    S_MUL_P,
    S_MUL_Q,
    S_MUL_D,
    S_PREP,
    S_GCD,
    S_GCD_WAIT,
    S_NUM_DIV,
    S_NUM_WAIT,
    S_DEN_DIV,
    S_DEN_WAIT,
    S_FINISH
  } state_e;

endpackage

`default_nettype wire

// ===== design/rau_div.sv =====
// ----------------------------------------------------------------------------
// rau_div
// Restoring unsigned divider that develops one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module rau_div #(
  parameter int unsigned N = 64
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         start_i,
  input  logic [N-1:0] dividend_i,
  input  logic [N-1:0] divisor_i,
  output logic         done_o,
  output logic [N-1:0] quot_o,
  output logic [N-1:0] rem_o
);

  localparam int unsigned CW = $clog2(N + 1);

  logic [N-1:0]  rem_q, rem_d, quot_q, quot_d, dsr_q;
  logic [CW-1:0] cnt_q, cnt_d;
  logic          run_q, run_d, done_q, done_d;
  logic [N:0]    trial;
  logic [N:0]    diff;

  assign trial = {rem_q, quot_q[N-1]};
  assign diff  = trial - {1'b0, dsr_q};

  always_comb begin
    rem_d  = rem_q;
    quot_d = quot_q;
    cnt_d  = cnt_q;
    run_d  = run_q;
    done_d = 1'b0;
    if (start_i) begin
      rem_d  = '0;
      quot_d = dividend_i;
      cnt_d  = CW'(N);
      run_d  = 1'b1;
    end else if (run_q) begin
      if (!diff[N]) begin
        rem_d  = diff[N-1:0];
        quot_d = {quot_q[N-2:0], 1'b1};
      end else begin
        rem_d  = trial[N-1:0];
        quot_d = {quot_q[N-2:0], 1'b0};
      end
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CW'(1)) begin
        run_d  = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      run_q  <= 1'b0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      run_q  <= run_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q  <= rem_d;
    quot_q <= quot_d;
    if (start_i) begin
      dsr_q <= divisor_i;
    end
  end

  assign done_o = done_q;
  assign quot_o = quot_q;
  assign rem_o  = rem_q;

endmodule

`default_nettype wire

// ===== design/rational_arithmetic_unit.sv =====
// ----------------------------------------------------------------------------
// rational_arithmetic_unit
// Exact add, subtract, multiply, divide and compare on two fractions.
// ----------------------------------------------------------------------------
// A request is taken when start is high and busy is low, and the result
// appears for exactly one cycle with done_o high; the receiver cannot stall
// it. One shared multiplier forms the cross products in states S_MUL_P,
// S_MUL_Q and S_MUL_D. A bit-serial divider runs Euclid's algorithm, one
// modulo per gcd step, and then does two divisions that reduce the fraction.
// Zero denominators, division by zero and unused modes are caught in S_CHECK,
// before the multiplier is used; comparisons end in S_MUL_D and zero results
// in S_PREP. Busy drops when the strobe starts, so the next request can be
// taken then.
`default_nettype none

module rational_arithmetic_unit #(
  parameter int unsigned VALUE_WIDTH = rau_pkg::ValueWidthDefault
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  output logic               busy,
  input  logic [2:0]         mode_i,
  input  logic signed [31:0] a_num_i,
  input  logic signed [31:0] a_den_i,
  input  logic signed [31:0] b_num_i,
  input  logic signed [31:0] b_den_i,
  output logic               done_o,
  output logic signed [31:0] res_num_o,
  output logic [30:0]        res_den_o,
  output logic               compare_true_o,
  output logic [1:0]         status_o
);

  import rau_pkg::*;

  localparam int unsigned W  = VALUE_WIDTH;
  localparam int unsigned PW = 2 * VALUE_WIDTH;
  localparam logic [PW-1:0] Lim = {{(W + 1){1'b0}}, {(W - 1){1'b1}}};

  state_e state_q, state_d;

  logic [2:0]            mode_q;
  logic signed [W-1:0]   an_q, ad_q, bn_q, bd_q;
  logic signed [W-1:0]   mul_a, mul_b;
  logic signed [PW-1:0]  prod;
  logic signed [PW-1:0]  p_q, q_q, d_q;
  logic signed [PW:0]    num_s;
  logic signed [PW-1:0]  den_s;
  logic [PW-1:0]         nmag, dmag;
  logic [PW-1:0]         nmag_q, dmag_q, ga_q, gb_q, rn_q;
  logic                  neg_q;

  logic                  div_start, div_done;
  logic [PW-1:0]         div_dvd, div_dsr, div_quot, div_rem;

  logic                  fin;
  logic [W-1:0]          fin_num;
  logic [W-2:0]          fin_den;
  logic                  fin_cmp;
  status_e               fin_status;
  logic [PW-1:0]         ovf_lim;
  logic [W-1:0]          rn_low;

  logic                  done_q;
  logic signed [31:0]    res_num_q;
  logic [30:0]           res_den_q;
  logic                  cmp_q;
  logic [1:0]            status_q;

  rau_div #(
    .N (PW)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dvd),
    .divisor_i  (div_dsr),
    .done_o     (div_done),
    .quot_o     (div_quot),
    .rem_o      (div_rem)
  );

  always_comb begin
    mul_a = an_q;
    mul_b = bd_q;
    case (state_q)
      S_MUL_P: begin
        mul_a = an_q;
        mul_b = (mode_q == MODE_MUL) ? bn_q : bd_q;
      end
      S_MUL_Q: begin
        mul_a = ad_q;
        mul_b = bn_q;
      end
      S_MUL_D: begin
        mul_a = ad_q;
        mul_b = bd_q;
      end
      default: begin
        mul_a = an_q;
        mul_b = bd_q;
      end
    endcase
  end

  assign prod = mul_a * mul_b;

  always_comb begin
    case (mode_q)
      MODE_ADD: num_s = {p_q[PW-1], p_q} + {q_q[PW-1], q_q};
      MODE_SUB: num_s = {p_q[PW-1], p_q} - {q_q[PW-1], q_q};
      default:  num_s = {p_q[PW-1], p_q};
    endcase
    den_s = (mode_q == MODE_DIV) ? q_q : d_q;
    nmag  = num_s[PW] ? PW'(-num_s) : num_s[PW-1:0];
    dmag  = den_s[PW-1] ? -den_s : den_s;
  end

  assign ovf_lim = neg_q ? Lim + 1'b1 : Lim;
  assign rn_low  = neg_q ? -rn_q[W-1:0] : rn_q[W-1:0];

  always_comb begin
    fin        = 1'b0;
    fin_num    = '0;
    fin_den    = (W - 1)'(1);
    fin_cmp    = 1'b0;
    fin_status = ST_OK;
    div_start  = 1'b0;
    div_dvd    = ga_q;
    div_dsr    = gb_q;
    case (state_q)
      S_CHECK: begin
        if (ad_q == '0 || bd_q == '0) begin
          fin        = 1'b1;
          fin_status = ST_ZERO_DEN;
        end else if (mode_q > MODE_LT) begin
          fin = 1'b1;
        end else if (mode_q == MODE_DIV && bn_q == '0) begin
          fin        = 1'b1;
          fin_status = ST_DIV_ZERO;
        end
      end
      S_MUL_D: begin
        if (mode_q == MODE_EQ) begin
          fin     = 1'b1;
          fin_cmp = (p_q == q_q);
        end else if (mode_q == MODE_LT) begin
          fin     = 1'b1;
          fin_cmp = (p_q < q_q);
        end
      end
      S_PREP: begin
        fin = (num_s == '0);
      end
      S_GCD: begin
        div_start = (gb_q != '0);
      end
      S_NUM_DIV: begin
        div_start = 1'b1;
        div_dvd   = nmag_q;
        div_dsr   = ga_q;
      end
      S_DEN_DIV: begin
        div_start = 1'b1;
        div_dvd   = dmag_q;
        div_dsr   = ga_q;
      end
      S_FINISH: begin
        fin = 1'b1;
        if (div_quot > Lim || rn_q > ovf_lim) begin
          fin_status = ST_OVERFLOW;
        end else begin
          fin_num = rn_low;
          fin_den = div_quot[W-2:0];
        end
      end
      default: begin
        fin = 1'b0;
      end
    endcase
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE:     if (start) state_d = S_CHECK;
      S_CHECK:    state_d = fin ? S_IDLE : S_MUL_P;
      S_MUL_P:    state_d = S_MUL_Q;
      S_MUL_Q:    state_d = S_MUL_D;
      S_MUL_D:    state_d = fin ? S_IDLE : S_PREP;
      S_PREP:     state_d = fin ? S_IDLE : S_GCD;
      S_GCD:      state_d = (gb_q != '0) ? S_GCD_WAIT : S_NUM_DIV;
      S_GCD_WAIT: if (div_done) state_d = S_GCD;
      S_NUM_DIV:  state_d = S_NUM_WAIT;
      S_NUM_WAIT: if (div_done) state_d = S_DEN_DIV;
      S_DEN_DIV:  state_d = S_DEN_WAIT;
      S_DEN_WAIT: if (div_done) state_d = S_FINISH;
      S_FINISH:   state_d = S_IDLE;
      default:    state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= fin;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == S_IDLE && start) begin
      mode_q <= mode_i;
      an_q   <= a_num_i[W-1:0];
      ad_q   <= a_den_i[W-1:0];
      bn_q   <= b_num_i[W-1:0];
      bd_q   <= b_den_i[W-1:0];
    end
    if (state_q == S_MUL_P) begin
      p_q <= prod;
    end
    if (state_q == S_MUL_Q) begin
      q_q <= prod;
    end
    if (state_q == S_MUL_D) begin
      d_q <= prod;
    end
    if (state_q == S_PREP) begin
      nmag_q <= nmag;
      dmag_q <= dmag;
      ga_q   <= nmag;
      gb_q   <= dmag;
      neg_q  <= num_s[PW] ^ den_s[PW-1];
    end
    if (state_q == S_GCD_WAIT && div_done) begin
      ga_q <= gb_q;
      gb_q <= div_rem;
    end
    if (state_q == S_NUM_WAIT && div_done) begin
      rn_q <= div_quot;
    end
    if (fin) begin
      res_num_q <= 32'(signed'(fin_num));
      res_den_q <= 31'(fin_den);
      cmp_q     <= fin_cmp;
      status_q  <= fin_status;
    end
  end

  assign busy           = (state_q != S_IDLE);
  assign done_o         = done_q;
  assign res_num_o      = res_num_q;
  assign res_den_o      = res_den_q;
  assign compare_true_o = cmp_q;
  assign status_o       = status_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni) done_o |-> !busy)
    else $error("Result strobe while the unit is busy.");

  assert property (@(posedge clk_i) disable iff (!rst_ni) start && !busy |=> busy)
    else $error("Accepted request did not make the unit busy.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
      div_done |-> (state_q == S_GCD_WAIT || state_q == S_NUM_WAIT ||
                    state_q == S_DEN_WAIT))
    else $error("Divider finished outside a wait state.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
      done_o |-> (res_den_o != '0))
    else $error("Result denominator is zero.");

endmodule

`default_nettype wire

// ===== tb/sv/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Self-checking testbench of the rational arithmetic unit.
// ----------------------------------------------------------------------------
// Requests are sent through the start/busy handshake. A predictor forms the
// cross products at full width, reduces by the gcd and applies the zero
// denominator, division by zero and overflow rules. A checker compares each
// strobed result with the oldest expected one.
`default_nettype none

module tb_top;
  import rau_pkg::*;

  typedef struct {
    logic signed [31:0] num;
    logic [30:0]        den;
    logic               cmp;
    logic [1:0]         status;
  } rational_res_t;

  logic               clk_i;
  logic               rst_ni;
  logic               start;
  logic               busy;
  logic [2:0]         mode_i;
  logic signed [31:0] a_num_i;
  logic signed [31:0] a_den_i;
  logic signed [31:0] b_num_i;
  logic signed [31:0] b_den_i;
  logic               done_o;
  logic signed [31:0] res_num_o;
  logic [30:0]        res_den_o;
  logic               compare_true_o;
  logic [1:0]         status_o;

  rational_res_t pending_q[$];
  int unsigned   n_errors;
  int unsigned   n_sent;
  int unsigned   n_checked;
  int unsigned   n_status[4];
  bit            quiet;

  rational_arithmetic_unit dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .mode_i         (mode_i),
    .a_num_i        (a_num_i),
    .a_den_i        (a_den_i),
    .b_num_i        (b_num_i),
    .b_den_i        (b_den_i),
    .done_o         (done_o),
    .res_num_o      (res_num_o),
    .res_den_o      (res_den_o),
    .compare_true_o (compare_true_o),
    .status_o       (status_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  initial begin
    #400000000;
    $display("FAIL");
    $finish;
  end

  function automatic logic [63:0] mag64(input logic signed [63:0] v);
    return v < 0 ? 64'(-v) : 64'(v);
  endfunction

  function automatic rational_res_t reduce_fraction(input logic [2:0] mode,
      input logic signed [31:0] an, input logic signed [31:0] ad,
      input logic signed [31:0] bn, input logic signed [31:0] bd);
    rational_res_t      r;
    logic signed [64:0] p;
    logic signed [64:0] q;
    logic signed [64:0] nv;
    logic signed [64:0] dv;
    logic [64:0]        nm;
    logic [64:0]        dm;
    logic [64:0]        x;
    logic [64:0]        y;
    logic [64:0]        t;
    logic               neg;
    r.num = '0;
    r.den = 31'd1;
    r.cmp = 1'b0;
    r.status = ST_OK;
    p = 65'(an) * 65'(bd);
    q = 65'(ad) * 65'(bn);
    if (ad == 0 || bd == 0) begin
      r.status = ST_ZERO_DEN;
      return r;
    end
    case (mode)
      MODE_ADD: begin
        nv = p + q;
        dv = 65'(ad) * 65'(bd);
      end
      MODE_SUB: begin
        nv = p - q;
        dv = 65'(ad) * 65'(bd);
      end
      MODE_MUL: begin
        nv = 65'(an) * 65'(bn);
        dv = 65'(ad) * 65'(bd);
      end
      MODE_DIV: begin
        if (bn == 0) begin
          r.status = ST_DIV_ZERO;
          return r;
        end
        nv = p;
        dv = q;
      end
      MODE_EQ: begin
        r.cmp = (p == q);
        return r;
      end
      MODE_LT: begin
        r.cmp = (p < q);
        return r;
      end
      default: return r;
    endcase
    if (nv == 0) return r;
    neg = (nv < 0) != (dv < 0);
    nm = nv < 0 ? -nv : nv;
    dm = dv < 0 ? -dv : dv;
    x = nm;
    y = dm;
    while (y != 0) begin
      t = x % y;
      x = y;
      y = t;
    end
    nm = nm / x;
    dm = dm / x;
    if (dm > 65'h7FFF_FFFF || nm > (neg ? 65'h8000_0000 : 65'h7FFF_FFFF)) begin
      r.status = ST_OVERFLOW;
      return r;
    end
    r.num = neg ? -32'(nm) : 32'(nm);
    r.den = 31'(dm);
    return r;
  endfunction

  task automatic send_request(input logic [2:0] mode,
      input logic signed [31:0] an, input logic signed [31:0] ad,
      input logic signed [31:0] bn, input logic signed [31:0] bd);
    while (!quiet && $urandom_range(99) < 7) begin
      start <= 1'b0;
      @(posedge clk_i);
    end
    start   <= 1'b1;
    mode_i  <= mode;
    a_num_i <= an;
    a_den_i <= ad;
    b_num_i <= bn;
    b_den_i <= bd;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    pending_q.push_back(reduce_fraction(mode, an, ad, bn, bd));
    n_sent++;
  endtask

  initial begin
    rational_res_t e;
    forever begin
      @(posedge clk_i);
      if (rst_ni && done_o) begin
        if (pending_q.size() == 0) begin
          $error("result with no request outstanding");
          n_errors++;
        end else begin
          e = pending_q.pop_front();
          n_checked++;
          n_status[e.status]++;
          if (res_num_o !== e.num) begin
            $error("res_num expected %0d actual %0d", e.num, res_num_o);
            n_errors++;
          end
          if (res_den_o !== e.den) begin
            $error("res_den expected %0d actual %0d", e.den, res_den_o);
            n_errors++;
          end
          if (compare_true_o !== e.cmp) begin
            $error("compare_true expected %0b actual %0b", e.cmp, compare_true_o);
            n_errors++;
          end
          if (status_o !== e.status) begin
            $error("status expected %0d actual %0d", e.status, status_o);
            n_errors++;
          end
        end
      end
    end
  end

  function automatic logic signed [31:0] rand_value();
    case ($urandom_range(5))
      0: return 32'($urandom_range(20)) - 32'sd10;
      1: return 32'($urandom_range(2000)) - 32'sd1000;
      2: return $urandom_range(1) ? 32'h7FFF_FFFF - $urandom_range(3)
                                  : 32'h8000_0000 + $urandom_range(3);
      3: return 32'($urandom_range(200000)) - 32'sd100000;
      default: return $urandom();
    endcase
  endfunction

  task automatic test_directed();
    logic [31:0] ext[6] = '{32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF, 32'd1, 32'd0,
                            32'h5555_AAAA};
    send_request(MODE_ADD, 1, 2, 1, 3);
    send_request(MODE_SUB, 1, 2, 1, 2);
    send_request(MODE_MUL, -3, 4, 4, -9);
    send_request(MODE_DIV, 2, 3, -4, 9);
    send_request(MODE_DIV, 2, 3, 0, 9);
    send_request(MODE_EQ, 1, 2, -1, -2);
    send_request(MODE_LT, 1, -2, 1, 3);
    send_request(MODE_LT, 1, 3, 1, 2);
    send_request(MODE_ADD, 1, 0, 1, 2);
    send_request(MODE_EQ, 1, 2, 1, 0);
    send_request(3'd6, 5, 7, 1, 2);
    send_request(3'd7, 5, 0, 1, 2);
    send_request(MODE_MUL, 0, -5, 7, 3);
    send_request(MODE_MUL, 32'h8000_0000, 1, 32'h8000_0000, 1);
    send_request(MODE_DIV, 32'h8000_0000, 1, -1, 1);
    send_request(MODE_MUL, -1, 32'h8000_0000, 1, 1);
    send_request(MODE_ADD, 32'h7FFF_FFFF, 32'h7FFF_FFFE, 1, 32'h7FFF_FFFF);
    for (int i = 0; i < 6; i++)
      send_request(3'(i), ext[i], ext[(i + 1) % 6] | 1, ext[(i + 2) % 6], ext[5 - i] | 1);
  endtask

  task automatic test_random(input int unsigned count);
    for (int unsigned i = 0; i < count; i++) begin
      quiet = (i >= count / 3 && i < count / 2);
      send_request($urandom_range(99) < 4 ? 3'($urandom_range(7, 6)) : 3'($urandom_range(5)),
                   rand_value(), rand_value(), rand_value(), rand_value());
    end
    quiet = 1'b0;
  endtask

  initial begin
    n_errors = 0;
    n_sent = 0;
    n_checked = 0;
    quiet = 1'b0;
    rst_ni = 1'b0;
    start = 1'b0;
    mode_i = '0;
    a_num_i = '0;
    a_den_i = '0;
    b_num_i = '0;
    b_den_i = '0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_random(1280);
    start <= 1'b0;
    while (pending_q.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    $display("Checked %0d of %0d requests: %0d ok, %0d zero denominator,", n_checked,
             n_sent, n_status[0], n_status[1]);
    $display("%0d division by zero, %0d overflow.", n_status[2], n_status[3]);
    if (n_errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

`default_nettype wire
